// File: src/formant_biquad_bank_mixer_top_macros.svh
// Assertion macros shared by the formant filter bank RTL.
`ifndef FORMANT_BIQUAD_BANK_MIXER_TOP_MACROS_SVH
`define FORMANT_BIQUAD_BANK_MIXER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("fbm assertion failed");
`define FBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("fbm assertion failed");
`define FBM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("fbm assertion failed");
`else
`define FBM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define FBM_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// File: src/fbm_pkg.sv
// Package with the constants, types and rounding helpers of the formant filter bank.
`timescale 1ns / 1ps
`default_nettype none
package fbm_pkg;

	localparam int NUM_FORMANTS  = 4;
	localparam int SAMPLE_BITS   = 24;
	localparam int NUM_COEF_REGS = 4;
	localparam int COEF_W        = 16;
	localparam int COEF_FRAC     = 14;
	localparam int Q15_FRAC      = 15;
	localparam int HIST_W        = 32;

	localparam int FIDX_W    = (NUM_FORMANTS > 1) ? $clog2(NUM_FORMANTS) : 1;
	localparam int CFG_IDX_W = $clog2(NUM_COEF_REGS + 2);
	localparam int CFG_DATA_W = 64;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = CFG_IDX_W'(0);
	localparam int                   REG_COEF_FIRST = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT       = CFG_IDX_W'(NUM_COEF_REGS + 1);

	// Datapath widths: the weighted sum of all filter outputs sets the widest operand.
	localparam int WET_BITS  = HIST_W + COEF_W + FIDX_W + 1;
	localparam int MUL_A_W   = WET_BITS - Q15_FRAC + 1;
	localparam int MUL_P_W   = MUL_A_W + COEF_W;
	localparam int ACC_W     = MUL_P_W + 1;

	localparam logic signed [COEF_W-1:0] MIX_DRY = COEF_W'(9830);
	localparam logic signed [COEF_W-1:0] MIX_WET = COEF_W'(22938);

	// Accumulator operations.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD     = 3'd2;
	localparam logic [OP_W-1:0] OP_SUB     = 3'd3;
	localparam logic [OP_W-1:0] OP_WET_ADD = 3'd4;
	localparam logic [OP_W-1:0] OP_WET_CLR = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [MUL_A_W-1:0] a;
		logic signed [COEF_W-1:0]  b;
	} mac_req_t;

	localparam logic signed [ACC_W:0] HALF_Q14 = (ACC_W+1)'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W:0] HALF_Q15 = (ACC_W+1)'(1) << (Q15_FRAC - 1);

	localparam logic signed [ACC_W-1:0] HIST_MAX =
		{{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] HIST_MIN =
		{{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SMP_MAX =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMP_MIN =
		{{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	// Round half up, then drop the fraction bits.
	function automatic logic signed [ACC_W-1:0] rnd_q14(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W:0] t;
		t = $signed({v[ACC_W-1], v}) + HALF_Q14;
		return ACC_W'(t >>> COEF_FRAC);
	endfunction

	function automatic logic signed [ACC_W-1:0] rnd_q15(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W:0] t;
		t = $signed({v[ACC_W-1], v}) + HALF_Q15;
		return ACC_W'(t >>> Q15_FRAC);
	endfunction

	function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > HIST_MAX) c = HIST_MAX;
		if (v < HIST_MIN) c = HIST_MIN;
		return HIST_W'(c);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
		input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > SMP_MAX) c = SMP_MAX;
		if (v < SMP_MIN) c = SMP_MIN;
		return SAMPLE_BITS'(c);
	endfunction

endpackage
`default_nettype wire

// File: src/fbm_if.sv
// Stream interfaces for the input samples and the shaped output samples.
`timescale 1ns / 1ps
`default_nettype none
interface fbm_in_if import fbm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface fbm_out_if import fbm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// File: src/fbm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/fbm_mac.sv
// Shared multiplier with a filter accumulator and a weighted-sum accumulator.
`timescale 1ns / 1ps
`default_nettype none
module fbm_mac import fbm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mac_req_t                req,
	output logic signed [ACC_W-1:0]      acc,
	output logic signed [ACC_W-1:0]      wet
);

	logic signed [MUL_P_W-1:0] prod_s1;
	logic [OP_W-1:0]           op_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   wet_q;
	logic signed [ACC_W-1:0]   prod_ext;

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= req.op;
		end
	end

	// The product is registered before it reaches either accumulator.
	always_ff @(posedge clk) begin
		prod_s1 <= $signed(req.a) * $signed(req.b);
		case (op_s1)
			OP_LOAD:    acc_q <= prod_ext;
			OP_ADD:     acc_q <= acc_q + prod_ext;
			OP_SUB:     acc_q <= acc_q - prod_ext;
			OP_WET_ADD: wet_q <= wet_q + prod_ext;
			OP_WET_CLR: wet_q <= '0;
			default: begin
			end
		endcase
	end

	assign acc = acc_q;
	assign wet = wet_q;

endmodule
`default_nettype wire

// File: src/formant_biquad_bank_mixer_top.sv
// Top level of the formant filter bank: bandpass biquads, dry/wet mix and tilt.
//
// One input sample is taken per transfer on the samples channel and exactly one
// shaped sample leaves per transfer on the shaped channel, in the same order.
// The user must write filter coefficients, gains, tilt and the enable bit through
// the cfg_we / cfg_index / cfg_data port only while the block is idle; the block
// does not enforce this. The two output history values of every filter live in a
// small RAM, one entry per filter, read once and written once per sample; the
// shared multiplier steps through the filters, so it sets the processing time.
// With processing enabled each filter in turn gets its b0, a1 and a2 products,
// its new output written back and its gain product; the wet sum, the dry/wet mix
// and, when the tilt is non-zero, the tilt step follow.
// When disabled the input is passed through unchanged. In both modes the next
// sample is taken only once the result has moved to the output register.
// The result waits in an output register; if the receiver stalls, the block
// finishes its work and holds in its final step until that register is free.
// Reset clears the enable bit, all coefficients, the tilt, the input and tilt
// history and the valid bits of the filter history, which then reads as zero.
`timescale 1ns / 1ps
`default_nettype none
`include "formant_biquad_bank_mixer_top_macros.svh"
module formant_biquad_bank_mixer_top import fbm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	fbm_in_if.sink                     samples,
	fbm_out_if.source                  shaped
);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
	localparam logic [ST_W-1:0] ST_MB   = 5'd1;
	localparam logic [ST_W-1:0] ST_MA1  = 5'd2;
	localparam logic [ST_W-1:0] ST_MA2  = 5'd3;
	localparam logic [ST_W-1:0] ST_Y    = 5'd4;
	localparam logic [ST_W-1:0] ST_WB   = 5'd5;
	localparam logic [ST_W-1:0] ST_G    = 5'd6;
	localparam logic [ST_W-1:0] ST_WET  = 5'd7;
	localparam logic [ST_W-1:0] ST_WR   = 5'd8;
	localparam logic [ST_W-1:0] ST_MX   = 5'd9;
	localparam logic [ST_W-1:0] ST_MD   = 5'd10;
	localparam logic [ST_W-1:0] ST_MS   = 5'd11;
	localparam logic [ST_W-1:0] ST_M    = 5'd12;
	localparam logic [ST_W-1:0] ST_T    = 5'd13;
	localparam logic [ST_W-1:0] ST_TW   = 5'd14;
	localparam logic [ST_W-1:0] ST_TR   = 5'd15;
	localparam logic [ST_W-1:0] ST_FIN  = 5'd16;

	// Configuration registers.
	logic                     enable_q;
	logic signed [COEF_W-1:0] tilt_q;
	logic [CFG_DATA_W-1:0]    coef_q [NUM_FORMANTS];

	// Sequencer and model state held in flip-flops.
	logic [ST_W-1:0]               state_q;
	logic [FIDX_W-1:0]             f_q;
	logic                          proc_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] xh0_q;
	logic signed [SAMPLE_BITS-1:0] xh1_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic [NUM_FORMANTS-1:0]       hist_valid_q;

	// Working values of the sample in flight.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS:0]   d_q;
	logic signed [HIST_W-1:0]      y_q;
	logic signed [MUL_A_W-1:0]     w_q;
	logic signed [SAMPLE_BITS-1:0] m_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic                          in_acc;
	logic                          last_f;
	logic                          out_free;
	logic                          ram_re;
	logic                          ram_we;
	logic [FIDX_W-1:0]             ram_raddr;
	logic [2*HIST_W-1:0]           ram_wdata;
	logic [2*HIST_W-1:0]           ram_rdata;
	logic signed [HIST_W-1:0]      hist_y1;
	logic signed [HIST_W-1:0]      hist_y2;
	logic [CFG_DATA_W-1:0]         coef_sel;
	logic signed [COEF_W-1:0]      c_b0;
	logic signed [COEF_W-1:0]      c_a1;
	logic signed [COEF_W-1:0]      c_a2;
	logic signed [COEF_W-1:0]      c_gain;
	logic signed [SAMPLE_BITS:0]   tilt_diff;
	logic signed [HIST_W-1:0]      y_new;
	logic signed [ACC_W-1:0]       mac_acc;
	logic signed [ACC_W-1:0]       mac_wet;
	mac_req_t                      mac_req;

	assign in_acc   = samples.valid && samples.ready;
	assign last_f   = (f_q == FIDX_W'(NUM_FORMANTS - 1));
	assign out_free = !out_valid_q || shaped.ready;

	assign samples.ready     = (state_q == ST_IDLE);
	assign shaped.valid      = out_valid_q;
	assign shaped.sample_out = out_data_q;

	// Configuration writes: registers for filters that do not exist are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			tilt_q   <= '0;
			for (int i = 0; i < NUM_FORMANTS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_ENABLE) begin
				enable_q <= cfg_data[0];
			end
			if (cfg_index == REG_TILT) begin
				tilt_q <= $signed(cfg_data[COEF_W-1:0]);
			end
			for (int i = 0; i < NUM_FORMANTS; i++) begin
				if (i < NUM_COEF_REGS && cfg_index == CFG_IDX_W'(REG_COEF_FIRST + i)) begin
					coef_q[i] <= cfg_data;
				end
			end
		end
	end

	// Coefficients of the filter being worked on.
	assign coef_sel = coef_q[f_q];
	assign c_b0     = $signed(coef_sel[COEF_W-1:0]);
	assign c_a1     = $signed(coef_sel[2*COEF_W-1:COEF_W]);
	assign c_a2     = $signed(coef_sel[3*COEF_W-1:2*COEF_W]);
	assign c_gain   = $signed(coef_sel[4*COEF_W-1:3*COEF_W]);

	// History entry: upper half is y[n-1], lower half is y[n-2]. An entry never
	// written since reset reads as zero.
	assign hist_y1 = hist_valid_q[f_q] ? $signed(ram_rdata[2*HIST_W-1:HIST_W]) : '0;
	assign hist_y2 = hist_valid_q[f_q] ? $signed(ram_rdata[HIST_W-1:0]) : '0;

	// The first filter's entry is fetched on the transfer, the next one while
	// the current filter's gain product is issued.
	assign ram_re    = (state_q == ST_IDLE && in_acc) || (state_q == ST_G && !last_f);
	assign ram_raddr = (state_q == ST_G) ? FIDX_W'(f_q + 1'b1) : '0;

	assign y_new     = sat_hist(rnd_q14(mac_acc));
	assign ram_we    = (state_q == ST_WB);
	assign ram_wdata = {y_new, hist_y1};

	assign tilt_diff = (SAMPLE_BITS+1)'(m_q) - (SAMPLE_BITS+1)'(prev_q);

	fbm_ram #(
		.WIDTH (2 * HIST_W),
		.DEPTH (NUM_FORMANTS)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (f_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Operands for the shared multiplier. Each product and its operation are
	// registered before the accumulators take them up.
	always_comb begin
		mac_req.op = OP_NONE;
		mac_req.a  = '0;
		mac_req.b  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mac_req.op = OP_WET_CLR;
				end
			end
			ST_MB: begin
				mac_req.op = OP_LOAD;
				mac_req.a  = MUL_A_W'(d_q);
				mac_req.b  = c_b0;
			end
			ST_MA1: begin
				mac_req.op = OP_SUB;
				mac_req.a  = MUL_A_W'(hist_y1);
				mac_req.b  = c_a1;
			end
			ST_MA2: begin
				mac_req.op = OP_SUB;
				mac_req.a  = MUL_A_W'(hist_y2);
				mac_req.b  = c_a2;
			end
			ST_G: begin
				mac_req.op = OP_WET_ADD;
				mac_req.a  = MUL_A_W'(y_q);
				mac_req.b  = c_gain;
			end
			ST_MX: begin
				mac_req.op = OP_LOAD;
				mac_req.a  = w_q;
				mac_req.b  = MIX_WET;
			end
			ST_MD: begin
				mac_req.op = OP_ADD;
				mac_req.a  = MUL_A_W'(x_q);
				mac_req.b  = MIX_DRY;
			end
			ST_T: begin
				if (tilt_q != '0) begin
					mac_req.op = OP_LOAD;
					mac_req.a  = MUL_A_W'(tilt_diff);
					mac_req.b  = tilt_q;
				end
			end
			default: begin
			end
		endcase
	end

	fbm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc    (mac_acc),
		.wet    (mac_wet)
	);

	// Sequencer and the state that the sample leaves behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			f_q          <= '0;
			proc_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			xh0_q        <= '0;
			xh1_q        <= '0;
			prev_q       <= '0;
			hist_valid_q <= '0;
		end else begin
			if (out_valid_q && shaped.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						f_q    <= '0;
						proc_q <= enable_q;
						state_q <= enable_q ? ST_MB : ST_FIN;
					end
				end
				ST_MB:  state_q <= ST_MA1;
				ST_MA1: state_q <= ST_MA2;
				ST_MA2: state_q <= ST_Y;
				ST_Y:   state_q <= ST_WB;
				ST_WB: begin
					hist_valid_q[f_q] <= 1'b1;
					state_q <= ST_G;
				end
				ST_G: begin
					if (last_f) begin
						state_q <= ST_WET;
					end else begin
						f_q     <= f_q + 1'b1;
						state_q <= ST_MB;
					end
				end
				ST_WET: state_q <= ST_WR;
				ST_WR: state_q <= ST_MX;
				ST_MX: state_q <= ST_MD;
				ST_MD: state_q <= ST_MS;
				ST_MS: state_q <= ST_M;
				ST_M:  state_q <= ST_T;
				ST_T: begin
					if (tilt_q != '0) begin
						prev_q  <= m_q;
						state_q <= ST_TW;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_TW: state_q <= ST_TR;
				ST_TR: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (proc_q) begin
							xh1_q <= xh0_q;
							xh0_q <= x_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data registers of the sample in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q   <= samples.sample_in;
					d_q   <= (SAMPLE_BITS+1)'(samples.sample_in) - (SAMPLE_BITS+1)'(xh1_q);
					res_q <= samples.sample_in;
				end
			end
			ST_WB: y_q <= y_new;
			ST_WR: w_q <= MUL_A_W'(rnd_q15(mac_wet));
			ST_M:  m_q <= sat_smp(rnd_q15(mac_acc));
			ST_T: begin
				if (tilt_q == '0) begin
					res_q <= m_q;
				end
			end
			ST_TR: res_q <= sat_smp(ACC_W'(m_q) - rnd_q15(mac_acc));
			ST_FIN: begin
				if (out_free) begin
					out_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// A transfer starts either the filter walk or the pass-through path.
	`FBM_ASSERT_NEXT(a_accept_start, clk, arst_n, in_acc, state_q == ST_MB || state_q == ST_FIN)
	// A finished result with a free output register is presented next cycle.
	`FBM_ASSERT_NEXT(a_fin_out, clk, arst_n, state_q == ST_FIN && out_free, shaped.valid && state_q == ST_IDLE)
	// With the tilt off the previous mix value is left alone.
	`FBM_ASSERT_NEXT(a_tilt_hold, clk, arst_n, state_q == ST_T && tilt_q == '0, $stable(prev_q))
	// The filter index never leaves the bank.
	`FBM_ASSERT_ALWAYS(a_f_range, clk, arst_n, 32'(f_q) < NUM_FORMANTS)
	// History is only written while a sample is being processed.
	`FBM_ASSERT_NOW(a_wb_proc, clk, arst_n, ram_we, proc_q && !samples.ready)

endmodule
`default_nettype wire

// File: tb/sv/formant_biquad_bank_mixer_top_test.sv
// Self-checking testbench for the formant filter bank with dry/wet mix and tilt.
`timescale 1ns / 1ps
module formant_biquad_bank_mixer_top_test;
	import fbm_pkg::*;

	// A stretch longer than this with no transfer on either channel means the block is stuck.
	localparam int IDLE_LIMIT    = 4000;
	// Cycles allowed after the last shaped sample before the registers are touched again.
	localparam int SETTLE_CYCLES = 48;
	localparam int ITEM_TARGET   = 2000;
	// Register indexes past the tilt register exist on the port but address nothing.
	localparam int REG_SPARE_FIRST = REG_TILT + 1;
	localparam int REG_SPARE_END   = 1 << CFG_IDX_W;

	localparam logic [SAMPLE_BITS-1:0] PASS_SET [6] =
		'{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};
	localparam logic [SAMPLE_BITS-1:0] TYPICAL_SET [5] =
		'{24'h7FFFFF, 24'h000000, 24'h000000, 24'h800000, 24'h000001};
	localparam logic [SAMPLE_BITS-1:0] EXTREME_SET [6] =
		'{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h000000};
	localparam logic [COEF_W-1:0] CORNER_WORDS [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

	// Shadow of the block: register copies, filter state and the shaped samples still owed.
	class formant_shaping;
		bit                            enabled;
		bit [CFG_DATA_W-1:0]           coef [NUM_FORMANTS];
		longint                        tilt;
		longint                        x_last, x_prior, mix_prev;
		longint                        y_last [NUM_FORMANTS];
		longint                        y_prior [NUM_FORMANTS];
		logic signed [SAMPLE_BITS-1:0] shaped_due [$];
		int                            errors;
		int                            seen;

		function longint half_up_shift(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint clamp(longint v, int bits);
			longint hi, lo;
			hi = (longint'(1) << (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			int k;
			k = int'(idx) - REG_COEF_FIRST;
			if (idx == REG_ENABLE) begin
				enabled = data[0];
			end else if (k >= 0 && k < NUM_COEF_REGS) begin
				if (k < NUM_FORMANTS)
					coef[k] = data;
			end else if (idx == REG_TILT) begin
				tilt = $signed(data[COEF_W-1:0]);
			end
		endfunction

		function logic signed [SAMPLE_BITS-1:0] shape_sample(logic signed [SAMPLE_BITS-1:0] s);
			longint x, d, wet, acc, y, w, m, r;
			longint b0, a1, a2, g;
			if (!enabled)
				return s;
			x = s;
			d = x - x_prior;
			wet = 0;
			for (int k = 0; k < NUM_FORMANTS; k++) begin
				b0 = $signed(coef[k][15:0]);
				a1 = $signed(coef[k][31:16]);
				a2 = $signed(coef[k][47:32]);
				g  = $signed(coef[k][63:48]);
				acc = b0 * d - a1 * y_last[k] - a2 * y_prior[k];
				y = clamp(half_up_shift(acc, COEF_FRAC), HIST_W);
				y_prior[k] = y_last[k];
				y_last[k] = y;
				wet += y * g;
			end
			x_prior = x_last;
			x_last = x;
			w = half_up_shift(wet, Q15_FRAC);
			m = clamp(half_up_shift(x * MIX_DRY + w * MIX_WET, Q15_FRAC), SAMPLE_BITS);
			r = m;
			if (tilt != 0) begin
				r = m - half_up_shift(tilt * (m - mix_prev), Q15_FRAC);
				mix_prev = m;
			end
			return SAMPLE_BITS'(clamp(r, SAMPLE_BITS));
		endfunction

		function void take_sample(logic signed [SAMPLE_BITS-1:0] s);
			shaped_due.push_back(shape_sample(s));
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task match_shaped(logic signed [SAMPLE_BITS-1:0] got);
			logic signed [SAMPLE_BITS-1:0] want;
			if (shaped_due.size() == 0) begin
				report($sformatf("shaped sample %0d arrived with none outstanding", got));
				return;
			end
			want = shaped_due.pop_front();
			if (got !== want)
				report($sformatf("shaped sample #%0d: got %0d, wanted %0d", seen, got, want));
			seen++;
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fbm_in_if  samples_ch ();
	fbm_out_if shaped_ch ();

	formant_biquad_bank_mixer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.shaped    (shaped_ch)
	);

	formant_shaping        bank;
	bit                    steady;      // when set, neither side idles
	int                    sent;
	int                    idle_cycles;
	logic [CFG_DATA_W-1:0] coeff_set [NUM_FORMANTS];

	// 20 ns clock period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Mostly back-to-back transfers, sometimes a short pause and now and then a long one,
	// so that pauses land on every step of the filter sequence and of the output hold.
	function automatic int rand_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 24);
		return $urandom_range(40, 200);
	endfunction

	// Offers one sample and returns at the rising edge where the transfer happens. Valid is
	// left high afterwards so that the next sample can follow without a bubble; each falling
	// edge carries exactly one assignment to it.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		int gap;
		gap = rand_gap();
		repeat (gap) begin
			@(negedge clk);
			samples_ch.valid <= 1'b0;
		end
		@(negedge clk);
		samples_ch.valid     <= 1'b1;
		samples_ch.sample_in <= s;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		bank.take_sample($signed(s));
		sent++;
	endtask

	// Stops offering samples and waits until every owed shaped sample has come out, then
	// leaves the block a little longer to finish its final step.
	task automatic drain();
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (bank.shaped_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		bank.write_reg(idx, data);
	endtask

	// Rewrites every register once the block is idle: the enable word, the filter words held
	// in coeff_set, the tilt word, and random data to the unused indexes, which must change
	// nothing.
	task automatic reprogram(input logic [CFG_DATA_W-1:0] en_word,
			input logic [CFG_DATA_W-1:0] tilt_word);
		drain();
		set_reg(REG_ENABLE, en_word);
		for (int k = 0; k < NUM_COEF_REGS; k++)
			set_reg(CFG_IDX_W'(REG_COEF_FIRST + k), coeff_set[k]);
		set_reg(REG_TILT, tilt_word);
		for (int i = REG_SPARE_FIRST; i < REG_SPARE_END; i++)
			set_reg(CFG_IDX_W'(i), {$urandom, $urandom});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: raises ready after a random stall and checks each shaped sample at the
	// rising edge of its transfer.
	initial begin
		int gap;
		shaped_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = rand_gap();
			repeat (gap) begin
				@(negedge clk);
				shaped_ch.ready <= 1'b0;
			end
			@(negedge clk);
			shaped_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!shaped_ch.valid);
			bank.match_shaped(shaped_ch.sample_out);
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (shaped_ch.valid && shaped_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[formant_biquad_bank_mixer_top] ERROR");
			$finish;
		end
	end

	// Main sequence: reset, a directed part, then random settings phases until the item
	// count is reached.
	initial begin
		logic [CFG_DATA_W-1:0]  en_word, tilt_word;
		logic [SAMPLE_BITS-1:0] s;
		int                     a1, a2, b0, lim, n;

		bank = new();
		idle_cycles = 0;
		sent = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.sample_in = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Straight after reset the block is disabled: samples pass through untouched and the
		// filter state must not move.
		foreach (PASS_SET[i])
			send_sample(PASS_SET[i]);

		// A plausible resonator on every filter with the tilt off: the output is the plain
		// mix and the previous mix is held. The enable word carries junk in its upper bits.
		foreach (coeff_set[k])
			coeff_set[k] = {16'h6000, 16'h3D54, 16'h9A70, 16'h0200};
		reprogram(64'hFFFF_0000_1234_0001, 64'h0);
		foreach (TYPICAL_SET[i])
			send_sample(TYPICAL_SET[i]);

		// Every field at its extreme and the strongest negative tilt: unstable filters drive
		// the history and the output into saturation, and the input swings full scale.
		foreach (coeff_set[k])
			coeff_set[k] = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
		reprogram(64'h1, 64'hFFFF_FFFF_FFFF_8000);
		foreach (EXTREME_SET[i])
			send_sample(EXTREME_SET[i]);

		// The opposite corners, with the largest positive tilt and junk above the tilt field.
		foreach (coeff_set[k])
			coeff_set[k] = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
		reprogram(64'h1, 64'h1234_0000_0000_7FFF);
		foreach (EXTREME_SET[i])
			send_sample(EXTREME_SET[i]);

		// Random phases. Most filters are stable resonators so the history carries real
		// signal; some get raw random words or corner values. One phase in ten is disabled.
		while (sent < ITEM_TARGET) begin
			en_word = {$urandom, $urandom};
			en_word[0] = ($urandom_range(0, 9) != 0);
			foreach (coeff_set[k]) begin
				case ($urandom_range(0, 9))
					0, 1: coeff_set[k] = {$urandom, $urandom};
					2: begin
						for (int f = 0; f < 4; f++)
							coeff_set[k][COEF_W*f +: COEF_W] = CORNER_WORDS[$urandom_range(0, 3)];
					end
					default: begin
						a2 = $urandom_range(12000, 16300);
						lim = 16384 + a2 - 300;
						a1 = int'($urandom_range(0, 2 * lim)) - lim;
						b0 = int'($urandom_range(0, 3000)) - 1500;
						coeff_set[k] = {16'($urandom), 16'(a2), 16'(a1), 16'(b0)};
					end
				endcase
			end
			tilt_word = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0, 1, 2: tilt_word[COEF_W-1:0] = '0;
				3: tilt_word[COEF_W-1:0] = 16'h8000;
				4: tilt_word[COEF_W-1:0] = 16'h7FFF;
				default: ;
			endcase
			steady = ($urandom_range(0, 3) == 0);
			reprogram(en_word, tilt_word);
			n = $urandom_range(10, 160);
			for (int i = 0; i < n && sent < ITEM_TARGET; i++) begin
				case ($urandom_range(0, 9))
					0: s = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
					1, 2, 3: s = SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
					default: s = SAMPLE_BITS'($urandom);
				endcase
				send_sample(s);
			end
		end

		drain();
		if (bank.errors == 0 && bank.shaped_due.size() == 0)
			$display("[formant_biquad_bank_mixer_top] OK");
		else
			$display("[formant_biquad_bank_mixer_top] ERROR");
		$finish;
	end

endmodule

// File: formant_biquad_bank_mixer_top.f
+incdir+src
src/fbm_pkg.sv
src/fbm_if.sv
src/fbm_ram.sv
src/fbm_mac.sv
src/formant_biquad_bank_mixer_top.sv
tb/sv/formant_biquad_bank_mixer_top_test.sv
